### rtl/conv2d_3x3_zero_pad_normalize_macros.svh
// Assertion macros used by the checker file of the 3x3 convolution block.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef CONV2D_3X3_ZERO_PAD_NORMALIZE_MACROS_SVH
`define CONV2D_3X3_ZERO_PAD_NORMALIZE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

### rtl/c2d_pkg.sv
// Shared types and constants of the 3x3 convolution block.
// No dependencies; used by the top level and its checker.
package c2d_pkg;

    // Input beat: one pixel or a flush marker.
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       flush;
    } t_in_beat;

    // Output beat: one result pixel.
    typedef struct packed {
        logic [7:0] result_pixel;
        logic       last_of_frame;
    } t_out_beat;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_DIVISOR = 3'd2;
    localparam logic [2:0] REG_K_TOP   = 3'd3;
    localparam logic [2:0] REG_K_MID   = 3'd4;
    localparam logic [2:0] REG_K_BOT   = 3'd5;

    localparam int          ADDR_W     = 6;
    localparam logic [7:0]  PIX_MAX    = 8'd255;
    localparam logic [47:0] K_MID_INIT = 48'h0000_0100_0000;

endpackage

### rtl/conv2d_3x3_zero_pad_normalize.sv
// Top level of the 3x3 zero-padded convolution with normalisation.
// Depends on c2d_pkg for beat types and register indexes.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) takes one pixel per beat
//   in raster order; after the frame the host sends width+1 flush beats.
//   Output channel (o_out_valid, i_out_stall, o_out_data) gives one result per
//   beat, the frame's final pixel flagged by last_of_frame.
//   Configuration goes through the APB-style port, 64-bit registers at 8*i.
// Sequence:
//   A beat without a result only passes write-back and window shift. A beat
//   with a result then passes the steps for the nine products, the sum, the
//   divider set-up, the restoring divider (one quotient bit per cycle) and
//   loading the output register. The next beat is accepted once the result is
//   in the output register, even while that result still waits to be taken.
// Reset clears the counters, window and output valid; the line memory is not
// cleared. A stalled result is held, and the block waits before overwriting it.
module conv2d_3x3_zero_pad_normalize #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  c2d_pkg::t_in_beat            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output c2d_pkg::t_out_beat           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [c2d_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Configuration registers.
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [12:0] r_divisor;
    logic [47:0] r_k_top, r_k_mid, r_k_bot;

    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            c2d_pkg::REG_WIDTH:   prdata = 64'(r_width);
            c2d_pkg::REG_HEIGHT:  prdata = 64'(r_height);
            c2d_pkg::REG_DIVISOR: prdata = 64'(r_divisor);
            c2d_pkg::REG_K_TOP:   prdata = 64'(r_k_top);
            c2d_pkg::REG_K_MID:   prdata = 64'(r_k_mid);
            c2d_pkg::REG_K_BOT:   prdata = 64'(r_k_bot);
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 11'd1024;
            r_height  <= 13'd1;
            r_divisor <= 13'd1;
            r_k_top   <= 48'd0;
            r_k_mid   <= c2d_pkg::K_MID_INIT;
            r_k_bot   <= 48'd0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                c2d_pkg::REG_WIDTH:   r_width   <= pwdata[10:0];
                c2d_pkg::REG_HEIGHT:  r_height  <= pwdata[12:0];
                c2d_pkg::REG_DIVISOR: r_divisor <= pwdata[12:0];
                c2d_pkg::REG_K_TOP:   r_k_top   <= pwdata[47:0];
                c2d_pkg::REG_K_MID:   r_k_mid   <= pwdata[47:0];
                c2d_pkg::REG_K_BOT:   r_k_bot   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero means one, large values saturate.
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb begin
        if (r_width == 11'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height == 13'd0) begin
            eff_h = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_height);
        end
    end

    // Control state.
    logic [2:0]    r_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [7:0]    r_pix;
    logic          r_last;
    logic          r_m_top, r_m_bot, r_m_left, r_m_right;
    logic [3:0]    r_k;
    logic          r_out_valid;
    c2d_pkg::t_out_beat r_out_data;

    logic in_acc;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Column with the out-of-range guard, and the output position it implies.
    logic [CW-1:0] col_c;
    logic          produce, beyond, is_last;
    logic [RW-1:0] out_r;
    logic [WW-1:0] out_c;

    always_comb begin
        col_c   = (32'(r_col) >= 32'(eff_w)) ? CW'(0) : r_col;
        produce = (32'(r_row) >= 32'd2) || ((32'(r_row) == 32'd1) && (col_c != CW'(0)));
        if (col_c == CW'(0)) begin
            out_r = r_row - RW'(2);
            out_c = eff_w - WW'(1);
        end else begin
            out_r = r_row - RW'(1);
            out_c = WW'(col_c) - WW'(1);
        end
        beyond  = 32'(out_r) >= 32'(eff_h);
        is_last = (32'(out_r) == 32'(eff_h) - 32'd1) && (out_c == eff_w - WW'(1));
    end

    // Line memory: both stored rows of one column share a word.
    logic [15:0] mem [MAX_WIDTH];
    logic [15:0] r_mem_q;
    logic [CW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            mem[r_addr] <= {r_pix, r_mem_q[15:8]};
        end
        r_mem_q <= mem[col_c];
    end

    // Window, products, sum and divider datapath.
    logic [7:0]         r_win  [3][3];
    logic signed [24:0] r_prod [3][3];
    logic signed [28:0] r_sum;
    logic [29:0]        r_rem;
    logic [20:0]        r_den;
    logic               r_neg;
    logic [8:0]         r_q;

    logic [47:0]        krow [3];
    logic               rmask [3];
    logic               cmask [3];
    logic signed [28:0] sum_c;
    logic signed [13:0] dsx, dz;
    logic [12:0]        dmag;
    logic [28:0]        smag;
    logic [29:0]        trial;
    logic [7:0]         res;

    always_comb begin
        krow[0]  = r_k_bot;
        krow[1]  = r_k_mid;
        krow[2]  = r_k_top;
        rmask[0] = r_m_top;
        rmask[1] = 1'b1;
        rmask[2] = r_m_bot;
        cmask[0] = r_m_left;
        cmask[1] = 1'b1;
        cmask[2] = r_m_right;
        sum_c = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                sum_c = sum_c + 29'(r_prod[a][b]);
            end
        end
        dsx   = 14'(signed'(r_divisor));
        dz    = (dsx == 14'sd0) ? 14'sd1 : dsx;
        dmag  = (dz < 0) ? 13'(-dz) : 13'(dz);
        smag  = (r_sum < 0) ? 29'(-r_sum) : 29'(r_sum);
        trial = 30'(r_den) << r_k;
        if (r_neg) begin
            res = 8'd0;
        end else if (r_q[8]) begin
            res = c2d_pkg::PIX_MAX;
        end else begin
            res = r_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        // Window shift on write-back.
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_win[a][b] <= 8'd0;
                end
            end
        end else if (r_state == S_EXEC) begin
            r_win[0][0] <= r_win[0][1];
            r_win[0][1] <= r_win[0][2];
            r_win[0][2] <= r_mem_q[7:0];
            r_win[1][0] <= r_win[1][1];
            r_win[1][1] <= r_win[1][2];
            r_win[1][2] <= r_mem_q[15:8];
            r_win[2][0] <= r_win[2][1];
            r_win[2][1] <= r_win[2][2];
            r_win[2][2] <= r_pix;
        end

        // Masked products, kernel flipped in both directions.
        if (r_state == S_MUL) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_prod[a][b] <= (rmask[a] && cmask[b])
                        ? 25'(signed'(krow[a][16*(2-b) +: 16]) * signed'({1'b0, r_win[a][b]}))
                        : 25'sd0;
                end
            end
        end

        if (r_state == S_SUM) begin
            r_sum <= sum_c;
        end

        // Divider set-up: round half away from zero by adding half the divisor.
        if (r_state == S_DINIT) begin
            r_rem <= 30'(smag) + 30'({dmag, 7'd0});
            r_den <= {dmag, 8'd0};
            r_neg <= (r_sum < 0) != (dz < 0);
            r_q   <= 9'd0;
        end else if (r_state == S_DIV) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_q   <= {r_q[7:0], 1'b1};
            end else begin
                r_q   <= {r_q[7:0], 1'b0};
            end
        end

        if (in_acc) begin
            r_pix  <= (!i_in_data.flush && (32'(r_row) < 32'(eff_h)))
                      ? i_in_data.pixel_value : 8'd0;
            r_addr <= col_c;
        end
        if (r_state == S_EXEC) begin
            r_last    <= is_last;
            r_m_top   <= out_r != RW'(0);
            r_m_bot   <= 32'(out_r) + 32'd1 < 32'(eff_h);
            r_m_left  <= out_c != WW'(0);
            r_m_right <= 32'(out_c) + 32'd1 < 32'(eff_w);
        end
        if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_data.result_pixel  <= res;
            r_out_data.last_of_frame <= r_last;
        end
    end

    // Sequencer, frame counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished result loads the output register; a taken beat clears it.
            if ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (produce && (beyond || is_last)) begin
                        r_col <= '0;
                        r_row <= '0;
                    end else if (32'(col_c) + 32'd1 >= 32'(eff_w)) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= col_c + CW'(1);
                    end
                    r_state <= (produce && !beyond) ? S_MUL : S_IDLE;
                end
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= S_DINIT;
                S_DINIT: begin
                    r_k     <= 4'd8;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_k == 4'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // A new frame size restarts the frame.
            if (cfg_we && ((cfg_idx == c2d_pkg::REG_WIDTH) ||
                           (cfg_idx == c2d_pkg::REG_HEIGHT))) begin
                r_col <= '0;
                r_row <= '0;
            end
        end
    end

endmodule

### rtl/c2d_checker.sv
// Port-level checker for the 3x3 convolution block, bound to its top level.
// Depends on c2d_pkg and conv2d_3x3_zero_pad_normalize_macros.svh.
`include "conv2d_3x3_zero_pad_normalize_macros.svh"

module c2d_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input c2d_pkg::t_out_beat o_out_data,
    input logic               pready
);

    // A stalled result beat stays offered and unchanged.
    `C2D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Every accepted input beat keeps the block busy for the following cycle.
    `C2D_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // The configuration port never inserts wait states.
    `C2D_ASSERT_NOW(a_pready_high, i_clk, i_rst_n, 1'b1, pready)

    // A result appears only after the block has been busy with a beat.
    `C2D_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind conv2d_3x3_zero_pad_normalize c2d_checker u_c2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
